@@ rtl/ctd_pkg.sv @@
// Package with the shared types, constants and helpers of the chunked transfer decoder.
`timescale 1ns / 1ps

package ctd_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [CountW-1:0] CapacityReset = 32'd4096;

  localparam logic [DataW-1:0] ChCr = 8'h0D;
  localparam logic [DataW-1:0] ChLf = 8'h0A;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdByte  = 1'b1;

  localparam logic KindData   = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef enum logic [6:0] {
    PH_STOPPED = 7'b0000001,
    PH_SIZE    = 7'b0000010,
    PH_EXT     = 7'b0000100,
    PH_LF      = 7'b0001000,
    PH_DATA    = 7'b0010000,
    PH_DCR     = 7'b0100000,
    PH_DLF     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [DataW-1:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ rtl/chunked_transfer_decoder_unit.sv @@
// Top level of the chunked transfer decoder: byte decoder with a small result queue.
//
//   Channel | Ports                                           | Direction
//   in      | in_valid, in_stall, in_cmd, in_message_length,  | request in
//           | in_data_byte                                    |
//   out     | out_valid, out_stall, out_kind, out_byte,       | request out
//           | out_count, out_last                             |
//   cfg     | cfg_wr_en, cfg_wr_data                          | register write
//
// One request is taken per cycle while in_stall is low; its results enter the result queue at the same edge.
// A result can leave the queue in the cycle after its request is taken.
// The input stalls only while fewer than two queue entries are free.
// Synchronous active-low reset stops the decoder, empties the queue and sets the
// capacity to 4096; there is no clearing pass.
`timescale 1ns / 1ps

module chunked_transfer_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [ctd_pkg::CountW-1:0] in_message_length,
  input  logic [ctd_pkg::DataW-1:0]  in_data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kind,
  output logic [ctd_pkg::DataW-1:0]  out_byte,
  output logic [ctd_pkg::CountW-1:0] out_count,
  output logic                      out_last,
  input  logic                      cfg_wr_en,
  input  logic [ctd_pkg::CountW-1:0] cfg_wr_data
);
  import ctd_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] size_r, size_nxt;
  logic              saw_digit_r, saw_digit_nxt;
  logic [CountW-1:0] msg_left_r, msg_left_nxt;
  logic [CountW-1:0] chunk_left_r, chunk_left_nxt;
  logic [CountW-1:0] decoded_r, decoded_nxt;
  logic [CountW-1:0] capacity_r;

  result_t           q_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0]  q_cnt_r, q_cnt_nxt;

  logic              in_acc, out_acc;
  logic              stop, finish, emit;
  logic [1:0]        n_push;
  hex_t              hx;
  result_t           res0, res1;
  logic [QPtrW-1:0]  wr_ptr_p1;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = q_cnt_r > QCntW'(QDepth - 2);
  assign out_valid = q_cnt_r != '0;
  assign hx        = hex_decode(in_data_byte);
  assign wr_ptr_p1 = wr_ptr_r + QPtrW'(1);

  always_comb begin
    phase_nxt      = phase_r;
    size_nxt       = size_r;
    saw_digit_nxt  = saw_digit_r;
    msg_left_nxt   = msg_left_r;
    chunk_left_nxt = chunk_left_r;
    decoded_nxt    = decoded_r;
    stop           = 1'b0;
    finish         = 1'b0;
    emit           = 1'b0;

    if (in_cmd == CmdStart) begin
      phase_nxt      = PH_SIZE;
      size_nxt       = '0;
      saw_digit_nxt  = 1'b0;
      msg_left_nxt   = in_message_length;
      chunk_left_nxt = '0;
      decoded_nxt    = '0;
      if (in_message_length == '0 || capacity_r == '0) begin
        phase_nxt = PH_STOPPED;
        finish    = 1'b1;
      end
    end else if (phase_r != PH_STOPPED) begin
      msg_left_nxt = msg_left_r - CountW'(1);
      case (phase_r)
        PH_SIZE, PH_EXT: begin
          if (phase_r == PH_SIZE && hx.is_hex) begin
            if (size_r[CountW-1 -: 4] != 4'd0) begin
              stop = 1'b1;
            end else begin
              size_nxt      = {size_r[CountW-5:0], hx.value};
              saw_digit_nxt = 1'b1;
            end
          end else if (phase_r == PH_SIZE && !saw_digit_r) begin
            stop = 1'b1;
          end else begin
            phase_nxt = PH_EXT;
            if (in_data_byte == ChLf) begin
              stop = 1'b1;
            end else if (in_data_byte == ChCr) begin
              phase_nxt = PH_LF;
            end
          end
        end
        PH_LF: begin
          if (in_data_byte != ChLf || size_r == '0 || size_r > msg_left_nxt
              || decoded_r >= capacity_r) begin
            stop = 1'b1;
          end else begin
            chunk_left_nxt = size_r;
            phase_nxt      = PH_DATA;
          end
        end
        PH_DATA: begin
          if (decoded_r < capacity_r) begin
            emit        = 1'b1;
            decoded_nxt = decoded_r + CountW'(1);
          end
          chunk_left_nxt = chunk_left_r - CountW'(1);
          if (chunk_left_r == CountW'(1)) begin
            phase_nxt = PH_DCR;
          end
        end
        PH_DCR: begin
          if (in_data_byte != ChCr) begin
            stop = 1'b1;
          end else begin
            phase_nxt = PH_DLF;
          end
        end
        PH_DLF: begin
          if (in_data_byte != ChLf) begin
            stop = 1'b1;
          end else begin
            phase_nxt     = PH_SIZE;
            size_nxt      = '0;
            saw_digit_nxt = 1'b0;
          end
        end
        default: begin
          stop = 1'b1;
        end
      endcase
      if (stop || msg_left_r == CountW'(1)) begin
        phase_nxt = PH_STOPPED;
        finish    = 1'b1;
      end
    end
  end

  always_comb begin
    res0.kind  = KindFinish;
    res0.data  = '0;
    res0.count = decoded_nxt;
    res0.last  = 1'b1;
    res1       = res0;
    n_push     = {1'b0, finish};
    if (emit) begin
      res0.kind  = KindData;
      res0.data  = in_data_byte;
      res0.count = decoded_r;
      res0.last  = !finish;
      n_push     = finish ? 2'd2 : 2'd1;
    end
    if (!in_acc) begin
      n_push = 2'd0;
    end
    q_cnt_nxt = q_cnt_r + QCntW'(n_push) - QCntW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_STOPPED;
      size_r       <= '0;
      saw_digit_r  <= 1'b0;
      msg_left_r   <= '0;
      chunk_left_r <= '0;
      decoded_r    <= '0;
      capacity_r   <= CapacityReset;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      q_cnt_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r      <= phase_nxt;
        size_r       <= size_nxt;
        saw_digit_r  <= saw_digit_nxt;
        msg_left_r   <= msg_left_nxt;
        chunk_left_r <= chunk_left_nxt;
        decoded_r    <= decoded_nxt;
      end
      wr_ptr_r <= wr_ptr_r + QPtrW'(n_push);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_p1] <= res1;
    end
  end

  assign out_kind  = q_r[rd_ptr_r].kind;
  assign out_byte  = q_r[rd_ptr_r].data;
  assign out_count = q_r[rd_ptr_r].count;
  assign out_last  = q_r[rd_ptr_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCntW'(QDepth))
    else $error("Result queue holds more entries than it has.");

  a_empty_start_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CmdStart && in_message_length == '0) |=> phase_r == PH_STOPPED)
    else $error("A start with an empty message did not stop the decoder.");

  a_ignored_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CmdByte && phase_r == PH_STOPPED && !out_acc)
      |=> q_cnt_r == $past(q_cnt_r))
    else $error("A byte taken while stopped produced a result.");

  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> chunk_left_r != '0)
    else $error("Chunk data phase with no bytes left in the chunk.");

endmodule
